FILE: rtl/matrix_multiply_engine_defines.svh
// Assertion macros for the matrix multiply engine.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MME_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
// No dependencies; imported by the interfaces and by all modules except mme_ram.
package mme_pkg;

   localparam int IDX_W     = 3;   // row/col index width
   localparam int OPC_W     = 2;
   localparam int VALUE_W   = 16;
   localparam int DOT_W     = 35;
   localparam int CFG_W     = 4;   // dimension register width
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_M    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_N    = 2'd2;

   localparam logic [CFG_W-1:0] ROWS_M_RESET    = 4'd3;
   localparam logic [CFG_W-1:0] INNER_DIM_RESET = 4'd4;
   localparam logic [CFG_W-1:0] COLS_N_RESET    = 4'd3;

   typedef enum logic [OPC_W-1:0] {
      OP_LOAD_M  = 2'd0,
      OP_LOAD_N  = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic             wr_m;
      logic             wr_n;
      logic             rd_en;
      logic             first;
      logic             last_k;
      logic             out_load;
      logic             out_last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] k;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic acc_done;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/mme_req_if.sv
// Request channel interface: opcode, element index and value.
// Depends on mme_pkg.
interface mme_req_if import mme_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OPC_W-1:0]          opcode;
   logic [IDX_W-1:0]          row;
   logic [IDX_W-1:0]          col;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, opcode, row, col, value, input ready);
   modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

FILE: rtl/mme_rsp_if.sv
// Response channel interface: one product element per transfer.
// Depends on mme_pkg.
interface mme_rsp_if import mme_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        out_row;
   logic [IDX_W-1:0]        out_col;
   logic signed [DOT_W-1:0] dot_value;
   logic                    last;

   modport source (output valid, out_row, out_col, dot_value, last, input ready);
   modport sink   (input valid, out_row, out_col, dot_value, last, output ready);
endinterface

FILE: rtl/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mme_ctrl.sv
// Controller: dimension registers, request decode and the r/c/k sequencer.
// Depends on mme_pkg.
module mme_ctrl import mme_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [OPC_W-1:0]     req_opcode,
   output logic                 req_ready,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  dp_status_type        status,
   output dp_cmd_type           cmd
);

   logic [CFG_W-1:0] rows_m_ff, inner_dim_ff, cols_n_ff;
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [CFG_W-1:0] nr, nk, nc;
   logic             accept, last_k, last_elem, emit;

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
      logic [CFG_W-1:0] lim;
      lim = CFG_W'(MAX_DIM);
      if (d == '0) begin
         return CFG_W'(1);
      end else if (d > lim) begin
         return lim;
      end
      return d;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff    <= ROWS_M_RESET;
         inner_dim_ff <= INNER_DIM_RESET;
         cols_n_ff    <= COLS_N_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS_M:    rows_m_ff    <= csr_wdata;
            CSR_INNER_DIM: inner_dim_ff <= csr_wdata;
            CSR_COLS_N:    cols_n_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign nr = clamp_dim(rows_m_ff);
   assign nk = clamp_dim(inner_dim_ff);
   assign nc = clamp_dim(cols_n_ff);

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign last_k    = ({1'b0, k_ff} == nk - CFG_W'(1));
   assign last_elem = ({1'b0, r_ff} == nr - CFG_W'(1)) && ({1'b0, c_ff} == nc - CFG_W'(1));
   assign emit      = (state_ff == ST_DRAIN) && status.acc_done && status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         r_ff     <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         k_ff     <= k_in;
      end
   end

   // next state and counters
   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_COMPUTE)) begin
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (last_k) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (emit) begin
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  if ({1'b0, c_ff} == nc - CFG_W'(1)) begin
                     c_in = '0;
                     r_in = r_ff + IDX_W'(1);
                  end else begin
                     c_in = c_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.wr_m     = accept && (req_opcode == OP_LOAD_M);
      cmd.wr_n     = accept && (req_opcode == OP_LOAD_N);
      cmd.rd_en    = (state_ff == ST_ISSUE);
      cmd.first    = (k_ff == '0);
      cmd.last_k   = last_k;
      cmd.out_load = emit;
      cmd.out_last = last_elem;
      cmd.row      = r_ff;
      cmd.col      = c_ff;
      cmd.k        = k_ff;
   end

endmodule

FILE: rtl/mme_datapath.sv
// Datapath: M and N element stores, multiply-accumulate pipeline, output register.
// Depends on mme_pkg and mme_ram.
module mme_datapath import mme_pkg::*; #(
   parameter int MAX_DIM      = 8,
   parameter int ELEMENT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic [IDX_W-1:0]          req_row,
   input  logic [IDX_W-1:0]          req_col,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [IDX_W-1:0]          rsp_out_row,
   output logic [IDX_W-1:0]          rsp_out_col,
   output logic signed [DOT_W-1:0]   rsp_dot_value,
   output logic                      rsp_last
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W = 2 * ELEMENT_BITS;

   logic signed [ELEMENT_BITS-1:0] elem, m_rd, n_rd;
   logic [ADDR_W-1:0]              wr_addr, rd_addr_m, rd_addr_n;
   logic                           in_range;

   logic                    s1_valid_ff, s1_first_ff, s1_last_ff;
   logic                    s2_valid_ff, s2_first_ff, s2_last_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [DOT_W-1:0]  prod_ext, acc_ff, acc_in;
   logic                    done_ff, done_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        out_row_ff, out_col_ff;
   logic signed [DOT_W-1:0] dot_ff;
   logic                    last_ff;

   // narrower elements keep their low bits; wider ones see the 16-bit pattern zero-extended
   assign elem      = ELEMENT_BITS'($unsigned(req_value));
   assign in_range  = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);
   assign wr_addr   = ADDR_W'(int'(req_row) * MAX_DIM + int'(req_col));
   assign rd_addr_m = ADDR_W'(int'(cmd.row) * MAX_DIM + int'(cmd.k));
   assign rd_addr_n = ADDR_W'(int'(cmd.k) * MAX_DIM + int'(cmd.col));

   mme_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(DEPTH)) u_store_m (
      .clock   (clock),
      .wr_en   (cmd.wr_m && in_range),
      .wr_addr (wr_addr),
      .wr_data (elem),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr_m),
      .rd_data (m_rd)
   );

   mme_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(DEPTH)) u_store_n (
      .clock   (clock),
      .wr_en   (cmd.wr_n && in_range),
      .wr_addr (wr_addr),
      .wr_data (elem),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr_n),
      .rd_data (n_rd)
   );

   assign prod_in  = PROD_W'(m_rd) * PROD_W'(n_rd);
   assign prod_ext = DOT_W'(prod_ff);   // sign-extend or wrap to the result width
   assign acc_in   = s2_first_ff ? prod_ext : acc_ff + prod_ext;

   always_comb begin
      done_in = done_ff;
      if (cmd.out_load) begin
         done_in = 1'b0;
      end else if (s2_valid_ff && s2_last_ff) begin
         done_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.rd_en;
         s2_valid_ff  <= s1_valid_ff;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first;
      s1_last_ff  <= cmd.last_k;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= prod_in;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.out_load) begin
         out_row_ff <= cmd.row;
         out_col_ff <= cmd.col;
         dot_ff     <= acc_ff;
         last_ff    <= cmd.out_last;
      end
   end

   assign status.acc_done = done_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_dot_value = dot_ff;
   assign rsp_last      = last_ff;

endmodule

FILE: rtl/matrix_multiply_engine.sv
// Matrix multiply engine, P = M x N over signed integer elements. A load request
// (opcode load M / load N) transfers one element into the matching store; indices at
// or beyond MAX_DIM are dropped. A compute request streams every element of P in
// row-major order on the response channel, the final one with last set. For each
// element, one store read of M and of N per cycle feeds the single multiply-accumulate
// unit, followed by the read, multiply and accumulate stages; the sum then goes into
// the output register once that is free, so the response side can stall a compute.
// The next request is taken as soon as the last element sits in the output register.
// Dimension registers of 0 act as 1, values above MAX_DIM act as MAX_DIM. Sums wrap
// to the 35-bit result width. Store entries hold nothing defined until loaded.
// Depends on mme_pkg, mme_req_if, mme_rsp_if, mme_ctrl, mme_datapath and the defines header.
`include "matrix_multiply_engine_defines.svh"

module matrix_multiply_engine import mme_pkg::*; #(
   parameter int MAX_DIM      = 8,
   parameter int ELEMENT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   mme_req_if.sink              req_ch,
   mme_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   dp_cmd_type    cmd;      // sequencer commands to the datapath
   dp_status_type status;   // accumulator done / output register free
   logic          req_ready;

   // controller: owns the dimension registers and walks r, c, k
   mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .cmd        (cmd)
   );

   assign req_ch.ready = req_ready;

   // datapath: element stores, MAC pipeline and response register
   mme_datapath #(.MAX_DIM(MAX_DIM), .ELEMENT_BITS(ELEMENT_BITS)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_row       (req_ch.row),
      .req_col       (req_ch.col),
      .req_value     (req_ch.value),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_out_row   (rsp_ch.out_row),
      .rsp_out_col   (rsp_ch.out_col),
      .rsp_dot_value (rsp_ch.dot_value),
      .rsp_last      (rsp_ch.last)
   );

   // a result only enters the output register once the sum is complete and the slot is free
   `MME_ASSERT_IMPL(a_load_ok, clock, reset, cmd.out_load, status.acc_done && status.out_free, "output loaded early")
   // store reads run only while no request can be taken
   `MME_ASSERT_IMPL(a_rd_busy, clock, reset, cmd.rd_en, !req_ch.ready, "store read while open")
   // after the final element is loaded the engine reopens for requests
   `MME_ASSERT_NEXT(a_reopen, clock, reset, cmd.out_load && cmd.out_last, req_ch.ready, "not idle after last")

endmodule
